// ===== sv/spsq_pkg.sv =====
package spsq_pkg;

    localparam int CAPACITY  = 16;
    localparam int PRIO_BITS = 8;
    localparam int TAG_BITS  = 8;
    localparam int ACT_BITS  = 2;

    // slot index and fill count widths
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [ACT_BITS-1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_PEEK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_HEAD,
        S_RESP
    } state_t;

    // physical slot of a logical position counted from the head, wraps at CAPACITY
    function automatic logic [IDX_W-1:0] phys_slot(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IDX_W + 1)'(CAPACITY))
        begin
            sum = sum - (IDX_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== sv/spsq_req_if.sv =====
interface spsq_req_if;
    import spsq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACT_BITS-1:0]  action;
    logic [PRIO_BITS-1:0] priority_req;
    logic [TAG_BITS-1:0]  task_id;

    modport source (output valid, output action, output priority_req, output task_id,
                    input ready);
    modport sink   (input valid, input action, input priority_req, input task_id,
                    output ready);
endinterface

// ===== sv/spsq_rsp_if.sv =====
interface spsq_rsp_if;
    import spsq_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [TAG_BITS-1:0]  head_task;
    logic [PRIO_BITS-1:0] head_priority;
    logic [CNT_W-1:0]     count;

    modport source (output valid, output status, output head_task, output head_priority,
                    output count, input ready);
    modport sink   (input valid, input status, input head_task, input head_priority,
                    input count, output ready);
endinterface

// ===== sv/spsq_ram.sv =====
module spsq_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/stable_sorted_priority_queue.sv =====
// Stable sorted priority queue. Holds up to CAPACITY (task tag, priority) entries in a
// ring in one simple dual-port RAM, kept in descending priority order from a head
// pointer. An enqueue walks from the tail toward the head, moving each lower-priority
// entry one slot back per cycle (read of the next slot overlaps the write of the
// current one) and drops the new entry behind the first entry of equal or higher
// priority, so equal priorities leave first-in first-out. A dequeue reads the head
// and advances the head pointer with no RAM write; a peek reads the head. One item is
// worked on at a time: a new request is taken only once the last one has loaded its
// result. Each beat in yields one result beat, held in an output register so that a
// stalled sink does not block the next acceptance. RAM contents need no clearing
// after reset; only entries at logical positions below the fill count are ever used.
module stable_sorted_priority_queue (
    input logic         clk,
    input logic         rst_n,
    spsq_req_if.sink    req,
    spsq_rsp_if.source  rsp
);
    import spsq_pkg::*;

    // control state
    state_t                state_reg;
    state_t                state_next;
    logic [IDX_W-1:0]      head_reg;     // physical slot of the head entry
    logic [CNT_W-1:0]      count_reg;    // entries held
    logic [IDX_W-1:0]      idx_reg;      // logical position under inspection

    // captured request
    logic [ACT_BITS-1:0]   act_reg;
    logic [PRIO_BITS-1:0]  prio_reg;
    logic [TAG_BITS-1:0]   tag_reg;

    // pending result
    status_t               res_status_reg;
    logic [TAG_BITS-1:0]   res_task_reg;
    logic [PRIO_BITS-1:0]  res_prio_reg;

    // output register
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [TAG_BITS-1:0]   out_task_reg;
    logic [PRIO_BITS-1:0]  out_prio_reg;
    logic [CNT_W-1:0]      out_count_reg;

    // ram ports
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    entry_t                ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                rd_entry;

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic                  out_free;
    logic                  shift;
    entry_t                new_entry;
    logic [IDX_W-1:0]      tail_off;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rd_entry  = entry_t'(ram_rdata);
    // inspected entry has lower priority than the new one: it moves back a slot
    assign shift     = (rd_entry.prio < prio_reg);
    assign new_entry = '{prio: prio_reg, tag: tag_reg};
    assign tail_off  = IDX_W'(count_reg - CNT_W'(1));

    spsq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.action)
                        ACT_ENQ:
                        begin
                            if (is_full)
                                state_next = S_RESP;
                            else if (is_empty)
                                state_next = S_INS;
                            else
                                state_next = S_SCAN;
                        end
                        ACT_DEQ, ACT_PEEK:
                        begin
                            state_next = is_empty ? S_RESP : S_HEAD;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!shift)
                    state_next = S_RESP;
                else if (idx_reg == '0)
                    state_next = S_INS;
                else
                    state_next = S_SCAN;
            end
            S_INS:  state_next = S_RESP;
            S_HEAD: state_next = S_RESP;
            S_RESP: state_next = out_free ? S_IDLE : S_RESP;
            default: state_next = S_IDLE;
        endcase
    end

    // ram control: the read of the next slot toward the head overlaps the write-back,
    // and during the tail walk the two never address the same slot in one cycle
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = phys_slot(head_reg, idx_reg + IDX_W'(1));
        ram_wdata = new_entry;
        ram_raddr = head_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.action == ACT_ENQ)
                    ram_raddr = phys_slot(head_reg, tail_off);
            end
            S_SCAN:
            begin
                ram_we    = 1'b1;
                ram_wdata = shift ? rd_entry : new_entry;
                ram_raddr = phys_slot(head_reg, idx_reg - IDX_W'(1));
            end
            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys_slot(head_reg, idx_reg);
            end
            S_HEAD, S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_HEAD:
                begin
                    if (act_reg == ACT_DEQ)
                    begin
                        head_reg  <= phys_slot(head_reg, IDX_W'(1));
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                S_SCAN:
                begin
                    if (!shift)
                        count_reg <= count_reg + CNT_W'(1);
                end
                S_INS:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                S_IDLE, S_RESP:
                begin
                end
                default:
                begin
                end
            endcase
            if (state_reg == S_RESP && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= req.action;
            prio_reg     <= req.priority_req;
            tag_reg      <= req.task_id;
            idx_reg      <= is_empty ? '0 : tail_off;
            res_task_reg <= '0;
            res_prio_reg <= '0;
            priority if (req.action == ACT_ENQ && is_full)
                res_status_reg <= ST_FULL;
            else if ((req.action == ACT_DEQ || req.action == ACT_PEEK) && is_empty)
                res_status_reg <= ST_EMPTY;
            else
                res_status_reg <= ST_OK;
        end
        if (state_reg == S_HEAD)
        begin
            res_task_reg <= rd_entry.tag;
            res_prio_reg <= rd_entry.prio;
        end
        if (state_reg == S_SCAN && shift && idx_reg != '0)
            idx_reg <= idx_reg - IDX_W'(1);
        if (state_reg == S_RESP && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_task_reg   <= res_task_reg;
            out_prio_reg   <= res_prio_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.head_task     = out_task_reg;
    assign rsp.head_priority = out_prio_reg;
    assign rsp.count         = out_count_reg;

    // fill count stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // fill count moves by at most one entry per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("fill count jumped");

    // the tail walk only runs with a free slot behind the tail
    a_scan_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_INS) |-> !is_full)
        else $error("insert walk on a full store");

    // a result beat is only loaded from the result state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result beat without a finished item");

    // a refused enqueue reports a full store
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_FULL) |-> out_count_reg == CNT_W'(CAPACITY))
        else $error("full status with free slots");
endmodule
